// ===== hdl/wpe_pkg.sv =====
// Shared types, constants and the channel scaling function of the WS2812 slot encoder.
package wpe_pkg;

  localparam int unsigned LED_BITS    = 24;
  localparam int unsigned MAX_LEDS    = 256;
  localparam int unsigned CNT_W       = $clog2(MAX_LEDS + 1);
  localparam int unsigned SLOT_W      = $clog2(LED_BITS + 1);
  localparam int unsigned CODE_W      = 16;
  localparam int unsigned GAIN_W      = 9;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ONE_CODE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CODE  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_RESET_CODE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = CFG_IDX_W'(3);

  localparam logic [GAIN_W-1:0] GAIN_FULL = GAIN_W'(256);

  // One queued LED job: GRB bits MSB first, plus what it emits
  typedef struct packed {
    logic [LED_BITS-1:0] grb;
    logic                has_data;
    logic                has_reset;
  } wpe_cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] one_code;
    logic [CODE_W-1:0] zero_code;
    logic [CODE_W-1:0] reset_code;
  } wpe_codes_t;

  // (ch * gain) >> 8, saturated to 255
  function automatic logic [7:0] scale_chan(input logic [7:0] ch, input logic [GAIN_W-1:0] gain);
    logic [16:0] prod;
    logic [8:0]  shifted;
    prod    = 17'(ch) * 17'(gain);
    shifted = prod[16:8];
    return shifted[8] ? 8'hFF : shifted[7:0];
  endfunction

endpackage

// ===== hdl/ws2812_pwm_slot_encoder_top.sv =====
// Top level of the WS2812 GRB PWM slot encoder: config registers and the front/queue/back chain.
//
// Each input transfer carries one LED color (red, green, blue) and a frame-end flag on tlast.
// Every channel is scaled by the brightness register (unsigned Q1.8, 256 = full, larger
// values still apply and saturate at 255), then the LED is sent as 24 PWM compare values,
// green, red, blue, most significant bit first, each one_code or zero_code. A frame-end
// LED adds one trailing slot carrying reset_code with tuser set. tlast on the output marks
// the last slot caused by an input item. LEDs past the 256th of a frame are dropped; a
// dropped LED with frame end still yields its reset slot. The serializer emits one slot per
// cycle while the sink accepts; the front end accepts an LED per cycle while the four-entry
// job queue has room. The output register holds a slot steady while the sink stalls, and the
// serializer advances only when that register is empty or being taken. Write configuration
// only when the block is idle; registers hold until written and never read back.
module ws2812_pwm_slot_encoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // LED input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [23:0]                    in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                           in_tlast,   // frame_end
  // slot output stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // slot_value[15:0]
  output logic                           out_tuser,  // is_reset
  output logic                           out_tlast,  // run_end
  // configuration write port
  input  logic                           cfg_we,
  input  logic [wpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpe_pkg::CODE_W-1:0]     cfg_wdata
);
  import wpe_pkg::*;

  logic [CODE_W-1:0] one_code_r;
  logic [CODE_W-1:0] zero_code_r;
  logic [CODE_W-1:0] reset_code_r;
  logic [GAIN_W-1:0] brightness_r;
  wpe_codes_t        codes;

  // queue hookup between front and back
  logic              q_push;
  logic              q_pop;
  logic              q_full;
  logic              q_not_empty;
  wpe_cmd_t          q_wr_cmd;
  wpe_cmd_t          q_head;

  // Configuration registers; an index beyond the list is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      one_code_r   <= '0;
      zero_code_r  <= '0;
      reset_code_r <= '0;
      brightness_r <= GAIN_FULL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ONE_CODE:   one_code_r   <= cfg_wdata;
        REG_ZERO_CODE:  zero_code_r  <= cfg_wdata;
        REG_RESET_CODE: reset_code_r <= cfg_wdata;
        REG_BRIGHTNESS: brightness_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign codes.one_code   = one_code_r;
  assign codes.zero_code  = zero_code_r;
  assign codes.reset_code = reset_code_r;

  // Front: accept, scale, count LEDs in the frame, drop what emits nothing
  wpe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .brightness (brightness_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (q_wr_cmd)
  );

  // Hold jobs so either side can stall on its own
  wpe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_wr_cmd),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back: one slot per transfer, reset slot last
  wpe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .codes       (codes),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ===== hdl/wpe_front.sv =====
// Front end: accepts LED items, scales the channels and tracks the frame LED count.
module wpe_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                        in_tlast,   // frame_end
  input  logic [wpe_pkg::GAIN_W-1:0]  brightness,
  input  logic                        q_full,
  output logic                        q_push,
  output wpe_pkg::wpe_cmd_t           q_cmd
);
  import wpe_pkg::*;

  logic [CNT_W-1:0] leds_r;
  logic [CNT_W-1:0] leds_nxt;
  logic             accept;
  logic             room;
  logic [7:0]       red_s;
  logic [7:0]       green_s;
  logic [7:0]       blue_s;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign room      = leds_r < CNT_W'(MAX_LEDS);

  assign red_s   = scale_chan(in_tdata[7:0], brightness);
  assign green_s = scale_chan(in_tdata[15:8], brightness);
  assign blue_s  = scale_chan(in_tdata[23:16], brightness);

  assign q_cmd.grb       = {green_s, red_s, blue_s};
  assign q_cmd.has_data  = room;
  assign q_cmd.has_reset = in_tlast;
  // drop items that would emit nothing
  assign q_push          = accept && (room || in_tlast);

  always_comb begin
    leds_nxt = leds_r;
    if (accept) begin
      if (in_tlast) begin
        leds_nxt = '0;
      end else if (room) begin
        leds_nxt = leds_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leds_r <= '0;
    end else begin
      leds_r <= leds_nxt;
    end
  end

endmodule

// ===== hdl/wpe_queue.sv =====
// Short job queue between the front end and the slot serializer.
module wpe_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wpe_pkg::wpe_cmd_t push_cmd,
  input  logic              pop,
  output wpe_pkg::wpe_cmd_t head,
  output logic              full,
  output logic              not_empty
);
  import wpe_pkg::*;

  wpe_cmd_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push;
  logic               do_pop;

  assign full      = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = cnt_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== hdl/wpe_back.sv =====
// Back end: serializes one queued job into bit slots and the reset slot.
module wpe_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wpe_pkg::wpe_codes_t         codes,
  input  logic                        q_not_empty,
  input  wpe_pkg::wpe_cmd_t           q_head,
  output logic                        q_pop,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [wpe_pkg::CODE_W-1:0]  out_tdata,  // slot_value
  output logic                        out_tuser,  // is_reset
  output logic                        out_tlast   // run_end
);
  import wpe_pkg::*;

  logic [LED_BITS-1:0] grb_r;
  logic [SLOT_W-1:0]   left_r;
  logic                rst_pend_r;
  logic                vld_r;
  logic [CODE_W-1:0]   val_r;
  logic                isr_r;
  logic                last_r;
  logic                active;
  logic                adv;
  logic                emit;
  logic                data_slot;
  logic                fin;

  assign active    = (left_r != '0) || rst_pend_r;
  assign adv       = !vld_r || out_tready;
  assign emit      = adv && active;
  assign data_slot = left_r != '0;
  assign fin       = emit && (data_slot ? (left_r == SLOT_W'(1) && !rst_pend_r) : 1'b1);
  // refill from the queue as the last slot of the current job leaves
  assign q_pop     = q_not_empty && (!active || fin);

  always_ff @(posedge clk) begin
    if (emit) begin
      if (data_slot) begin
        val_r  <= grb_r[LED_BITS-1] ? codes.one_code : codes.zero_code;
        isr_r  <= 1'b0;
        last_r <= (left_r == SLOT_W'(1)) && !rst_pend_r;
      end else begin
        val_r  <= codes.reset_code;
        isr_r  <= 1'b1;
        last_r <= 1'b1;
      end
    end
    if (q_pop) begin
      grb_r <= q_head.grb;
    end else if (emit && data_slot) begin
      grb_r <= {grb_r[LED_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r     <= '0;
      rst_pend_r <= 1'b0;
      vld_r      <= 1'b0;
    end else begin
      if (adv) begin
        vld_r <= active;
      end
      if (q_pop) begin
        left_r     <= q_head.has_data ? SLOT_W'(LED_BITS) : '0;
        rst_pend_r <= q_head.has_reset;
      end else if (emit) begin
        if (data_slot) begin
          left_r <= left_r - SLOT_W'(1);
        end else begin
          rst_pend_r <= 1'b0;
        end
      end
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = val_r;
  assign out_tuser  = isr_r;
  assign out_tlast  = last_r;

endmodule

// ===== hdl/wpe_checker.sv =====
// Port-level checker for the slot encoder, bound to the top level.
module wpe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Hold a stalled slot unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled output slot changed");

  // The reset slot always closes the run of its item
  a_reset_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("reset slot without run end");

  // Reset drops any pending slot
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

endmodule

bind ws2812_pwm_slot_encoder_top wpe_checker u_wpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
